// ----- hdl/modexp_pkg.sv -----
// Shared constants and control types for the modular exponentiation block.
`timescale 1ns / 1ps

package modexp_pkg;

    // Operand width of the modular arithmetic; fields stay 32 bits.
    localparam int MOD_BITS  = 32;
    localparam int FIELD_W   = 32;
    localparam int EXP_WIDTH = 32;
    localparam int CNT_W     = $clog2(MOD_BITS);
    localparam int BIT_IDX_W = $clog2(EXP_WIDTH);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

    localparam logic [FIELD_W-1:0] EXPONENT_RESET = FIELD_W'(65537);
    localparam logic [FIELD_W-1:0] MODULUS_RESET  = FIELD_W'(1);

    // Operand routing for one modular multiply.
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_SQUARE,
        OP_MULT
    } opsel_t;

    typedef struct packed {
        logic   load;
        logic   exp_zero;
        logic   mul_go;
        opsel_t sel;
    } modexp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic mul_done;
    } modexp_status_t;

endpackage

// ----- hdl/modexp_dp.sv -----
// Datapath: base and accumulator registers and the bit-serial modular multiplier.
`timescale 1ns / 1ps

module modexp_dp
    import modexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  modexp_cmd_t          cmd,
    input  logic [FIELD_W-1:0]   base,
    input  logic [FIELD_W-1:0]   modulus,
    output modexp_status_t       status,
    output logic [FIELD_W-1:0]   power_mod
);

    logic [MOD_BITS-1:0] m;
    logic [MOD_BITS-1:0] one_mod;

    logic [MOD_BITS-1:0] base_reg, base_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] r_reg, r_next;
    logic [MOD_BITS-1:0] x_reg, x_next;
    logic [MOD_BITS-1:0] y_reg, y_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    opsel_t              sel_reg, sel_next;

    logic [MOD_BITS-1:0] r_dbl;
    logic [MOD_BITS-1:0] r_step;
    logic                mul_done;

    // a + b mod m for a, b below m; the carry bit covers the overflow case.
    function automatic logic [MOD_BITS-1:0] add_mod(
        input logic [MOD_BITS-1:0] a,
        input logic [MOD_BITS-1:0] b,
        input logic [MOD_BITS-1:0] md
    );
        logic [MOD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, md})
        begin
            s = s - {1'b0, md};
        end
        return s[MOD_BITS-1:0];
    endfunction

    assign m       = MOD_BITS'(modulus);
    assign one_mod = (m == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    // One multiplier bit per cycle, most significant first.
    assign r_dbl    = add_mod(r_reg, r_reg, m);
    assign r_step   = y_reg[MOD_BITS-1] ? add_mod(r_dbl, x_reg, m) : r_dbl;
    assign mul_done = run_reg && (cnt_reg == '0);

    always_comb
    begin
        base_next = base_reg;
        acc_next  = acc_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        sel_next  = sel_reg;

        if (cmd.load)
        begin
            base_next = MOD_BITS'(base);
            if (cmd.exp_zero)
            begin
                acc_next = MOD_BITS'(1);
            end
            else if (m == '0)
            begin
                acc_next = '0;
            end
            else
            begin
                acc_next = one_mod;
            end
        end

        if (cmd.mul_go)
        begin
            r_next   = '0;
            cnt_next = CNT_W'(MOD_BITS - 1);
            run_next = 1'b1;
            sel_next = cmd.sel;
            unique case (cmd.sel)
                OP_REDUCE:
                begin
                    // base * (1 mod m) reduces the base
                    x_next = acc_reg;
                    y_next = base_reg;
                end
                OP_SQUARE:
                begin
                    x_next = acc_reg;
                    y_next = acc_reg;
                end
                OP_MULT:
                begin
                    x_next = base_reg;
                    y_next = acc_reg;
                end
                default:
                begin
                    x_next = acc_reg;
                    y_next = acc_reg;
                end
            endcase
        end
        else if (run_reg)
        begin
            r_next = r_step;
            y_next = {y_reg[MOD_BITS-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                run_next = 1'b0;
                if (sel_reg == OP_REDUCE)
                begin
                    base_next = r_step;
                end
                else
                begin
                    acc_next = r_step;
                end
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            sel_reg <= OP_SQUARE;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        acc_reg  <= acc_next;
        r_reg    <= r_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
    end

    assign status.mod_zero = (m == '0);
    assign status.mul_done = mul_done;
    assign power_mod       = FIELD_W'(acc_reg);

endmodule

// ----- hdl/modexp_ctrl.sv -----
// Controller: walks the exponent bits and sequences the modular multiplies.
`timescale 1ns / 1ps

module modexp_ctrl
    import modexp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [FIELD_W-1:0]   exponent,
    input  modexp_status_t       status,
    output modexp_cmd_t          cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_ML_GO,
        ST_ML_WAIT,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [BIT_IDX_W-1:0]  bit_idx_reg, bit_idx_next;
    logic                  exp_zero;
    logic                  exp_bit;

    assign exp_zero = (exponent == '0);
    assign exp_bit  = exponent[bit_idx_reg];

    always_comb
    begin
        state_next   = state_reg;
        bit_idx_next = bit_idx_reg;
        cmd.load     = 1'b0;
        cmd.exp_zero = exp_zero;
        cmd.mul_go   = 1'b0;
        cmd.sel      = OP_SQUARE;
        busy         = 1'b1;
        done         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load     = 1'b1;
                    bit_idx_next = BIT_IDX_W'(EXP_WIDTH - 1);
                    state_next   = (exp_zero || status.mod_zero) ? ST_FINISH : ST_RED_GO;
                end
            end
            ST_RED_GO:
            begin
                cmd.mul_go = 1'b1;
                cmd.sel    = OP_REDUCE;
                state_next = ST_RED_WAIT;
            end
            ST_RED_WAIT:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_SQ_GO;
                end
            end
            ST_SQ_GO:
            begin
                cmd.mul_go = 1'b1;
                cmd.sel    = OP_SQUARE;
                state_next = ST_SQ_WAIT;
            end
            ST_SQ_WAIT:
            begin
                if (status.mul_done)
                begin
                    if (exp_bit)
                    begin
                        state_next = ST_ML_GO;
                    end
                    else if (bit_idx_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                        state_next   = ST_SQ_GO;
                    end
                end
            end
            ST_ML_GO:
            begin
                cmd.mul_go = 1'b1;
                cmd.sel    = OP_MULT;
                state_next = ST_ML_WAIT;
            end
            ST_ML_WAIT:
            begin
                if (status.mul_done)
                begin
                    if (bit_idx_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg - BIT_IDX_W'(1);
                        state_next   = ST_SQ_GO;
                    end
                end
            end
            ST_FINISH:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_idx_reg <= bit_idx_next;
        end
    end

endmodule

// ----- hdl/modular_exponentiation.sv -----
// Top level: configuration registers, controller and datapath of the modular exponentiator.
//
//  channel   signals                                   request taken when
//  -------   ---------------------------------------   ------------------------
//  input     start, busy, base[31:0]                   start && !busy
//  result    done, power_mod[31:0]                     done (one cycle)
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// One request at a time. Exponent zero or modulus zero: result in the cycle after accept.
// Otherwise the exponent is scanned over all 32 bits: a base reduction, then per bit a
// square and, for a set bit, a multiply, each run bit-serially in the multiplier; the
// next request can be taken in the cycle after the result. Reset clears the controller
// and restores exponent 65537, modulus 1. Config writes are ready only while idle with
// start low; the receiver takes done unconditionally.
`timescale 1ns / 1ps

module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [FIELD_W-1:0]    base,
    output logic                  done,
    output logic [FIELD_W-1:0]    power_mod,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [FIELD_W-1:0]    cfg_data
);

    logic [FIELD_W-1:0] exponent_reg, exponent_next;
    logic [FIELD_W-1:0] modulus_reg, modulus_next;
    modexp_cmd_t        cmd;
    modexp_status_t     status;

    // Hold off writes while a request is being taken so its settings stay fixed.
    assign cfg_ready = !busy && !start;

    // Drop writes to indexes beyond the register list.
    always_comb
    begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_EXPONENT)
            begin
                exponent_next = cfg_data;
            end
            else if (cfg_index == REG_MODULUS)
            begin
                modulus_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
        end
        else
        begin
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
        end
    end

    modexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .exponent (exponent_reg),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    modexp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .base      (base),
        .modulus   (modulus_reg),
        .status    (status),
        .power_mod (power_mod)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for modular_exponentiation: queued requests, predicted powers, checks.
`timescale 1ns / 1ps

module testbench;
    import modexp_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 280;
    localparam int CALM_TAIL    = 40;
    localparam int TAIL_CYCLES  = 64;
    localparam int QUIET_LIMIT  = 12000;

    // Indexes that map to no register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        REQ_BASE,
        REQ_CFG,
        REQ_DRAIN
    } req_kind_t;

    typedef struct {
        req_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [FIELD_W-1:0]    data;
    } request_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [FIELD_W-1:0]   base = '0;
    logic                 done;
    logic [FIELD_W-1:0]   power_mod;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]   cfg_data = '0;

    request_t             pending[$];
    logic [FIELD_W-1:0]   power_mod_q[$];
    logic [FIELD_W-1:0]   exp_cfg = EXPONENT_RESET;
    logic [FIELD_W-1:0]   mod_cfg = MODULUS_RESET;
    logic                 base_fire = 1'b0;
    logic                 cfg_fire = 1'b0;
    logic                 result_fire = 1'b0;
    int                   quiet_cycles = 0;
    int                   error_count = 0;
    int                   gap_left = 0;
    logic                 idle_on = 1'b1;

    modular_exponentiation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .base      (base),
        .done      (done),
        .power_mod (power_mod),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    // Left-to-right square-and-multiply with exact double-width products.
    function automatic logic [FIELD_W-1:0] predict_power(
        input logic [FIELD_W-1:0] b_in,
        input logic [FIELD_W-1:0] e,
        input logic [FIELD_W-1:0] m_in
    );
        logic [63:0] mask;
        logic [63:0] m;
        logic [63:0] b;
        logic [63:0] acc;
        int          top;
        int          i;
        mask = {64{1'b1}} >> (64 - MOD_BITS);
        m    = {32'b0, m_in} & mask;
        b    = {32'b0, b_in} & mask;
        top  = -1;
        for (i = 0; i < EXP_WIDTH; i++)
            if (e[i])
                top = i;
        if (top < 0)
            return FIELD_W'(1);
        if (m == 64'd0)
            return '0;
        b   = b % m;
        acc = 64'd1 % m;
        for (i = top; i >= 0; i--)
        begin
            acc = (acc * acc) % m;
            if (e[i])
                acc = (acc * b) % m;
        end
        return acc[FIELD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic push_base(input logic [FIELD_W-1:0] b);
        request_t r;
        r.kind = REQ_BASE;
        r.idx  = '0;
        r.data = b;
        pending.push_back(r);
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] d);
        request_t r;
        r.kind = REQ_CFG;
        r.idx  = idx;
        r.data = d;
        pending.push_back(r);
    endtask

    task automatic push_drain();
        request_t r;
        r.kind = REQ_DRAIN;
        r.idx  = '0;
        r.data = '0;
        pending.push_back(r);
    endtask

    // Driver: present requests at the falling edge, hold each until taken.
    always @(negedge clk)
    begin
        logic     nxt_start;
        logic     nxt_cfg;
        logic     calm;
        request_t head;
        nxt_start = start;
        nxt_cfg   = cfg_valid;
        calm      = pending.size() < CALM_TAIL;
        if (rst_n)
        begin
            if (start && base_fire)
            begin
                nxt_start = 1'b0;
                if (!calm && idle_on && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 6);
                if ($urandom_range(0, 15) == 0)
                    idle_on = !idle_on;
            end
            if (cfg_valid && cfg_fire)
                nxt_cfg = 1'b0;
            // Hold off the next request after a result now and then.
            if (result_fire && !calm && idle_on && $urandom_range(0, 1) == 0)
                gap_left = $urandom_range(1, 6);
            if (calm)
                gap_left = 0;
            if (!nxt_start && !nxt_cfg)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending.size() != 0)
                begin
                    head = pending[0];
                    case (head.kind)
                        REQ_BASE:
                        begin
                            nxt_start = 1'b1;
                            base <= head.data;
                            void'(pending.pop_front());
                        end
                        REQ_CFG:
                        begin
                            if (power_mod_q.size() == 0)
                            begin
                                nxt_cfg = 1'b1;
                                cfg_index <= head.idx;
                                cfg_data <= head.data;
                                void'(pending.pop_front());
                            end
                        end
                        REQ_DRAIN:
                        begin
                            if (power_mod_q.size() == 0)
                                void'(pending.pop_front());
                        end
                        default:
                            void'(pending.pop_front());
                    endcase
                end
            end
        end
        start <= nxt_start;
        cfg_valid <= nxt_cfg;
    end

    // Monitor: sample at the rising edge, track registers, predict and check.
    always @(posedge clk)
    begin
        logic [FIELD_W-1:0] want;
        if (rst_n)
        begin
            base_fire   = start && !busy;
            cfg_fire    = cfg_valid && cfg_ready;
            result_fire = (done === 1'b1);
            if (result_fire)
            begin
                if (power_mod_q.size() == 0)
                    report_mismatch("result with no request pending", power_mod, '0);
                else
                begin
                    want = power_mod_q.pop_front();
                    if (power_mod !== want)
                        report_mismatch("power_mod", power_mod, want);
                end
            end
            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_EXPONENT: exp_cfg = cfg_data;
                    REG_MODULUS:  mod_cfg = cfg_data;
                    default: ;
                endcase
            end
            if (base_fire)
                power_mod_q.push_back(predict_power(base, exp_cfg, mod_cfg));
            quiet_cycles = (base_fire || cfg_fire || result_fire) ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int                 issued;
        int                 burst;
        int                 k;
        logic [FIELD_W-1:0] e;
        logic [FIELD_W-1:0] m;
        logic [FIELD_W-1:0] b;

        // Directed: reset registers give modulus one.
        push_base(32'd5);
        push_base(32'd0);
        // Exponent zero gives one, for modulus one and modulus zero.
        push_cfg(REG_EXPONENT, 32'd0);
        push_base(32'hFFFF_FFFF);
        push_cfg(REG_MODULUS, 32'd0);
        push_base(32'd7);
        // Modulus zero with a nonzero exponent.
        push_cfg(REG_EXPONENT, 32'd65537);
        push_base(32'd7);
        push_base(32'hFFFF_FFFF);
        // All-ones registers.
        push_cfg(REG_MODULUS, 32'hFFFF_FFFF);
        push_cfg(REG_EXPONENT, 32'hFFFF_FFFF);
        push_base(32'd0);
        push_base(32'd1);
        push_base(32'hFFFF_FFFF);
        push_base(32'hFFFF_FFFE);
        push_base(32'd2);
        // Base above the modulus must be reduced first.
        push_cfg(REG_EXPONENT, 32'd1);
        push_cfg(REG_MODULUS, 32'hFFFF_FFFB);
        push_base(32'hFFFF_FFFF);
        push_base(32'hFFFF_FFFB);
        push_cfg(REG_EXPONENT, 32'h8000_0000);
        push_cfg(REG_MODULUS, 32'd1000003);
        push_base(32'd12345);
        // Writes to unmapped indexes leave the registers alone.
        push_cfg(REG_SPARE_LO, $urandom());
        push_cfg(REG_SPARE_HI, $urandom());
        push_base(32'd54321);
        push_cfg(REG_EXPONENT, 32'd2);
        push_cfg(REG_MODULUS, 32'd97);
        push_base(32'd96);
        push_base(32'd0);
        push_drain();

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       e = 32'd0;
                1:       e = 32'd1;
                2:       e = 32'hFFFF_FFFF;
                3:       e = 32'd65537;
                4:       e = $urandom_range(2, 255);
                default: e = $urandom();
            endcase
            case ($urandom_range(0, 9))
                0:       m = 32'd0;
                1:       m = 32'd1;
                2:       m = 32'd2;
                3:       m = 32'hFFFF_FFFF;
                4:       m = $urandom_range(3, 255);
                5:       m = $urandom() | 32'h1;
                default: m = $urandom() | 32'h8000_0000;
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                push_cfg(REG_EXPONENT, e);
                push_cfg(REG_MODULUS, m);
            end
            else
            begin
                push_cfg(REG_MODULUS, m);
                push_cfg(REG_EXPONENT, e);
            end
            if ($urandom_range(0, 5) == 0)
                push_cfg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
            burst = $urandom_range(8, 24);
            for (k = 0; k < burst && issued < RANDOM_ITEMS; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       b = 32'd0;
                    1:       b = 32'd1;
                    2:       b = m - 32'd1;
                    3:       b = m;
                    4:       b = 32'hFFFF_FFFF;
                    5, 6:    b = (m > 32'd1) ? $urandom_range(0, m - 32'd1) : $urandom();
                    default: b = $urandom();
                endcase
                push_base(b);
                issued++;
            end
            // Let the block empty out now and then before the next request.
            if ($urandom_range(0, 3) == 0)
                push_drain();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || start || cfg_valid)
            @(posedge clk);
        while (power_mod_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/modexp_pkg.sv
hdl/modexp_dp.sv
hdl/modexp_ctrl.sv
hdl/modular_exponentiation.sv
bench/testbench.sv
